// ----- sv/apsc_pkg.sv -----
// apsc_pkg: shared constants, handshake structs and residue helpers for the
// Atkin prime sieve counter. No dependencies.
package apsc_pkg;

    localparam int MAX_LIMIT_DEF = 65535;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 16;

    typedef struct packed {
        logic start;
        logic ack;
    } t_seq_ctrl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

    // v mod 12 for v below 60
    function automatic logic [3:0] mod12_small(input logic [6:0] v);
        logic [6:0] t;
        t = v;
        for (int k = 0; k < 4; k++) begin
            if (t >= 7'd12) begin
                t = t - 7'd12;
            end
        end
        return t[3:0];
    endfunction

    // (m*m) mod 12 for a residue m
    function automatic logic [3:0] sq_mod12(input logic [3:0] m);
        logic [3:0] r;
        case (m)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd1;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd9;
            4'd4:    r = 4'd4;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd0;
            4'd7:    r = 4'd1;
            4'd8:    r = 4'd4;
            4'd9:    r = 4'd9;
            4'd10:   r = 4'd4;
            4'd11:   r = 4'd1;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/apsc_bitmap.sv -----
// apsc_bitmap: one-bit-per-number scratch memory, one write and one
// registered read port. No dependencies.
module apsc_bitmap #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/apsc_seq.sv -----
// apsc_seq: sieve sequencer with one shared add/subtract unit driving the
// bitmap through clear, isqrt, quadratic toggles, setting 2 and 3, square
// elimination, count. Depends on apsc_pkg.
module apsc_seq #(
    parameter int AW        = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  apsc_pkg::t_seq_ctrl         i_ctrl,
    input  logic [AW-1:0]               i_bound,
    output apsc_pkg::t_seq_stat         o_stat,
    output logic [apsc_pkg::OUT_W-1:0]  o_count,
    output logic                        o_we,
    output logic [AW-1:0]               o_waddr,
    output logic                        o_wdata,
    output logic [AW-1:0]               o_raddr,
    input  logic                        i_rdata
);

    localparam int RW = (AW + 1) / 2;
    localparam int NW = AW + 3;
    localparam int CW = apsc_pkg::OUT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_ROOT, S_QCHK, S_QWR, S_SET2, S_SET3,
        S_SRD, S_SCHK, S_SCLR, S_CNT, S_CLAST, S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_bound, n_bound;
    logic [NW-1:0]   r_idx, n_idx;
    logic [RW-1:0]   r_root, n_root;
    logic [AW:0]     r_rsq, n_rsq;
    logic [RW-1:0]   r_x, n_x, r_y, n_y;
    logic [3:0]      r_xm, n_xm, r_ym, n_ym;
    logic [AW-1:0]   r_x2, n_x2, r_y2, n_y2;
    logic [AW+1:0]   r_x3, n_x3;
    logic [1:0]      r_form, n_form;
    logic [RW:0]     r_n, n_n;
    logic [NW-1:0]   r_nsq, n_nsq;
    logic            r_pend, n_pend;
    logic [CW-1:0]   r_count, n_count;

    logic [3:0]      w_sx, w_sy, w_res;
    logic [NW-1:0]   w_a, w_b, w_sum, w_bound_n;
    logic            w_ok, w_qual;

    // shared quadratic-form unit
    always_comb begin
        w_sx = apsc_pkg::sq_mod12(r_xm);
        w_sy = apsc_pkg::sq_mod12(r_ym);
        w_a  = (r_form == 2'd0) ? NW'({r_x2, 2'b00}) : NW'(r_x3);
        w_b  = NW'(r_y2);
        w_sum = (r_form == 2'd2) ? (w_a - w_b) : (w_a + w_b);
        w_bound_n = NW'(r_bound);
        case (r_form)
            2'd0: begin
                w_res = apsc_pkg::mod12_small(7'(w_sx) * 7'd4 + 7'(w_sy));
                w_ok  = (w_res == 4'd1) || (w_res == 4'd5);
            end
            2'd1: begin
                w_res = apsc_pkg::mod12_small(7'(w_sx) * 7'd3 + 7'(w_sy));
                w_ok  = (w_res == 4'd7);
            end
            2'd2: begin
                w_res = apsc_pkg::mod12_small(7'(w_sx) * 7'd3 + 7'd12 - 7'(w_sy));
                w_ok  = (w_res == 4'd11) && (r_x > r_y);
            end
            default: begin
                w_res = 4'd0;
                w_ok  = 1'b0;
            end
        endcase
        w_qual = w_ok && (w_sum <= w_bound_n);
    end

    always_comb begin
        n_state = r_state;
        n_bound = r_bound;
        n_idx   = r_idx;
        n_root  = r_root;
        n_rsq   = r_rsq;
        n_x     = r_x;
        n_y     = r_y;
        n_xm    = r_xm;
        n_ym    = r_ym;
        n_x2    = r_x2;
        n_x3    = r_x3;
        n_y2    = r_y2;
        n_form  = r_form;
        n_n     = r_n;
        n_nsq   = r_nsq;
        n_pend  = r_pend;
        n_count = r_count;
        o_we    = 1'b0;
        o_waddr = r_idx[AW-1:0];
        o_wdata = 1'b0;
        o_raddr = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_ctrl.start) begin
                    n_bound = i_bound;
                    n_idx   = '0;
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                o_we = 1'b1;
                if (r_idx == w_bound_n) begin
                    n_root  = '0;
                    n_rsq   = (AW+1)'(1);
                    n_state = S_ROOT;
                end else begin
                    n_idx = r_idx + NW'(1);
                end
            end
            S_ROOT: begin
                if (r_rsq <= {1'b0, r_bound}) begin
                    n_root = r_root + RW'(1);
                    n_rsq  = r_rsq + (AW+1)'({r_root, 1'b1}) + (AW+1)'(2);
                end else if (r_root == '0) begin
                    n_state = S_SET2;
                end else begin
                    n_x     = RW'(1);
                    n_y     = RW'(1);
                    n_xm    = 4'd1;
                    n_ym    = 4'd1;
                    n_x2    = AW'(1);
                    n_x3    = (AW+2)'(3);
                    n_y2    = AW'(1);
                    n_form  = 2'd0;
                    n_state = S_QCHK;
                end
            end
            S_QCHK, S_QWR: begin
                if (r_state == S_QCHK && w_qual) begin
                    o_raddr = w_sum[AW-1:0];
                    n_idx   = w_sum;
                    n_state = S_QWR;
                end else begin
                    if (r_state == S_QWR) begin
                        o_we    = 1'b1;
                        o_wdata = ~i_rdata;
                    end
                    n_state = S_QCHK;
                    if (r_form != 2'd2) begin
                        n_form = r_form + 2'd1;
                    end else begin
                        n_form = 2'd0;
                        if (r_y == r_root) begin
                            n_y  = RW'(1);
                            n_ym = 4'd1;
                            n_y2 = AW'(1);
                            if (r_x == r_root) begin
                                n_state = S_SET2;
                            end else begin
                                n_x  = r_x + RW'(1);
                                n_xm = (r_xm == 4'd11) ? 4'd0 : r_xm + 4'd1;
                                n_x2 = r_x2 + AW'({r_x, 1'b1});
                                n_x3 = r_x3 + (AW+2)'({r_x, 1'b1})
                                     + (AW+2)'({r_x, 2'b10});
                            end
                        end else begin
                            n_y  = r_y + RW'(1);
                            n_ym = (r_ym == 4'd11) ? 4'd0 : r_ym + 4'd1;
                            n_y2 = r_y2 + AW'({r_y, 1'b1});
                        end
                    end
                end
            end
            S_SET2: begin
                o_waddr = AW'(2);
                o_wdata = 1'b1;
                o_we    = (r_bound >= AW'(2));
                n_state = S_SET3;
            end
            S_SET3: begin
                o_waddr = AW'(3);
                o_wdata = 1'b1;
                o_we    = (r_bound >= AW'(3));
                n_n     = (RW+1)'(5);
                n_nsq   = NW'(25);
                n_state = S_SRD;
            end
            S_SRD: begin
                o_raddr = AW'(r_n);
                if (r_n > {1'b0, r_root}) begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_count = '0;
                    n_state = S_CNT;
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_rdata) begin
                    n_idx   = r_nsq;
                    n_state = S_SCLR;
                end else begin
                    n_n     = r_n + (RW+1)'(1);
                    n_nsq   = r_nsq + NW'({r_n, 1'b1});
                    n_state = S_SRD;
                end
            end
            S_SCLR: begin
                if (r_idx <= w_bound_n) begin
                    o_we  = 1'b1;
                    n_idx = r_idx + r_nsq;
                end else begin
                    n_n     = r_n + (RW+1)'(1);
                    n_nsq   = r_nsq + NW'({r_n, 1'b1});
                    n_state = S_SRD;
                end
            end
            S_CNT: begin
                n_pend = 1'b1;
                if (r_pend) begin
                    n_count = r_count + CW'(i_rdata);
                end
                if (r_idx == w_bound_n) begin
                    n_state = S_CLAST;
                end else begin
                    n_idx = r_idx + NW'(1);
                end
            end
            S_CLAST: begin
                n_count = r_count + CW'(i_rdata);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_ctrl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
        r_bound <= n_bound;
        r_idx   <= n_idx;
        r_root  <= n_root;
        r_rsq   <= n_rsq;
        r_x     <= n_x;
        r_y     <= n_y;
        r_xm    <= n_xm;
        r_ym    <= n_ym;
        r_x2    <= n_x2;
        r_x3    <= n_x3;
        r_y2    <= n_y2;
        r_form  <= n_form;
        r_n     <= n_n;
        r_nsq   <= n_nsq;
        r_count <= n_count;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_count     = r_count;

`ifndef SYNTH
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (o_waddr <= r_bound))
        else $error("bitmap write beyond bound");

    a_toggle_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QWR) |-> (o_we && (o_waddr == $past(o_raddr))))
        else $error("toggle write address differs from read");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> (r_state == S_IDLE))
        else $error("start while busy");

    a_count_le_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((AW+CW)'(r_count) <= (AW+CW)'(r_bound)))
        else $error("prime count exceeds bound");
`endif

endmodule

// ----- sv/atkin_prime_sieve_counter_unit.sv -----
// Concurrency: one request at a time, set by the single bitmap port pair and the
// shared add/subtract unit; a new request is taken while a result waits.
// Reset: synchronous active-low i_rst_n clears control; bitmap needs no clearing.
// Depends on apsc_pkg, apsc_seq, apsc_bitmap.
module atkin_prime_sieve_counter_unit #(
    parameter int MAX_LIMIT = apsc_pkg::MAX_LIMIT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [apsc_pkg::IN_W-1:0]   i_upper_bound,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [apsc_pkg::OUT_W-1:0]  o_prime_count
);

    localparam int DEPTH = MAX_LIMIT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (AW > apsc_pkg::IN_W) ? AW : apsc_pkg::IN_W;

    apsc_pkg::t_seq_ctrl             w_ctrl;
    apsc_pkg::t_seq_stat             w_stat;
    logic [CW-1:0]                   w_in_ext;
    logic [AW-1:0]                   w_bound;
    logic [apsc_pkg::OUT_W-1:0]      w_count;
    logic                            w_we, w_wdata, w_rdata;
    logic [AW-1:0]                   w_waddr, w_raddr;
    logic                            r_out_valid;
    logic [apsc_pkg::OUT_W-1:0]      r_out_count;

    assign w_in_ext = CW'(i_upper_bound);
    assign w_bound  = (w_in_ext > CW'(MAX_LIMIT)) ? AW'(MAX_LIMIT) : w_in_ext[AW-1:0];

    assign o_ready      = w_stat.idle;
    assign w_ctrl.start = i_valid && w_stat.idle;
    assign w_ctrl.ack   = w_stat.done && (!r_out_valid || i_ready);

    apsc_seq #(
        .AW        (AW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_bound (w_bound),
        .o_stat  (w_stat),
        .o_count (w_count),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata)
    );

    apsc_bitmap #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.ack) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_ctrl.ack) begin
            r_out_count <= w_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_prime_count = r_out_count;

endmodule

// ----- bench/tb_atkin_prime_sieve_counter_unit.sv -----
// Self-checking bench for atkin_prime_sieve_counter_unit: a queue-fed driver,
// a result monitor and a behavioral prime counter for the expected values.
// Depends on apsc_pkg and the atkin_prime_sieve_counter_unit RTL.
module tb_atkin_prime_sieve_counter_unit;

    localparam int IN_W          = apsc_pkg::IN_W;
    localparam int OUT_W         = apsc_pkg::OUT_W;
    localparam int MAX_LIMIT_DEF = apsc_pkg::MAX_LIMIT_DEF;

    typedef struct {
        logic [IN_W-1:0] bound;
        int unsigned     tx_idle_pct;
        int unsigned     rx_stall_pct;
        bit              drain_first;
    } t_bound_req;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic [IN_W-1:0]   i_upper_bound = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [OUT_W-1:0]  o_prime_count;

    t_bound_req        bound_queue[$];
    t_bound_req        next_req;
    logic [OUT_W-1:0]  count_queue[$];
    logic [OUT_W-1:0]  want_count;
    bit                sieve_bits [0:MAX_LIMIT_DEF];
    int unsigned       rx_stall_pct   = 0;
    int unsigned       total_requests = 0;
    int unsigned       result_count   = 0;
    int unsigned       fail_count     = 0;

    atkin_prime_sieve_counter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_upper_bound (i_upper_bound),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_prime_count (o_prime_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [OUT_W-1:0] count_primes(input logic [IN_W-1:0] ub);
        int unsigned lim, root, x, y, n, k, sq, total;
        lim = 32'(ub);
        if (lim > MAX_LIMIT_DEF) begin
            lim = MAX_LIMIT_DEF;
        end
        for (k = 0; k <= lim; k++) begin
            sieve_bits[k] = 1'b0;
        end
        root = 0;
        while ((root + 1) * (root + 1) <= lim) begin
            root++;
        end
        for (x = 1; x <= root; x++) begin
            for (y = 1; y <= root; y++) begin
                n = 4 * x * x + y * y;
                if (n <= lim && (n % 12 == 1 || n % 12 == 5)) begin
                    sieve_bits[n] = ~sieve_bits[n];
                end
                n = 3 * x * x + y * y;
                if (n <= lim && n % 12 == 7) begin
                    sieve_bits[n] = ~sieve_bits[n];
                end
                if (x > y) begin
                    n = 3 * x * x - y * y;
                    if (n <= lim && n % 12 == 11) begin
                        sieve_bits[n] = ~sieve_bits[n];
                    end
                end
            end
        end
        if (lim >= 2) begin
            sieve_bits[2] = 1'b1;
        end
        if (lim >= 3) begin
            sieve_bits[3] = 1'b1;
        end
        for (n = 5; n <= root; n++) begin
            if (sieve_bits[n]) begin
                sq = n * n;
                for (k = sq; k <= lim; k += sq) begin
                    sieve_bits[k] = 1'b0;
                end
            end
        end
        total = 0;
        for (k = 0; k <= lim; k++) begin
            total += 32'(sieve_bits[k]);
        end
        return total[OUT_W-1:0];
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                count_queue.push_back(count_primes(i_upper_bound));
            end
            if (!i_valid || o_ready) begin
                if (bound_queue.size() != 0 &&
                    !(bound_queue[0].drain_first && count_queue.size() != 0) &&
                    $urandom_range(99) >= bound_queue[0].tx_idle_pct) begin
                    next_req = bound_queue.pop_front();
                    rx_stall_pct = next_req.rx_stall_pct;
                    i_valid <= 1'b1;
                    i_upper_bound <= next_req.bound;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (count_queue.size() == 0) begin
                    $error("prime_count: no request pending, actual %0d", o_prime_count);
                    fail_count++;
                end else begin
                    want_count = count_queue.pop_front();
                    if (o_prime_count !== want_count) begin
                        $error("prime_count: expected %0d, actual %0d",
                               want_count, o_prime_count);
                        fail_count++;
                    end
                end
                result_count++;
            end
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        int          directed [] = '{0, 1, 2, 3, 4, 5, 6, 7, 11, 12, 13, 24, 25, 49,
                                     120, 121, 168, 169, 1000, 65535};
        int unsigned tx_pct [4] = '{0, 75, 0, 34};
        int unsigned rx_pct [4] = '{0, 0, 75, 34};
        int unsigned pick;
        t_bound_req  req;

        foreach (directed[k]) begin
            req.bound        = IN_W'(directed[k]);
            req.tx_idle_pct  = 0;
            req.rx_stall_pct = 0;
            req.drain_first  = 1'b0;
            bound_queue.push_back(req);
        end
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 25; k++) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    req.bound = IN_W'($urandom_range(255));
                end else if (pick < 95) begin
                    req.bound = IN_W'($urandom_range(2047, 256));
                end else begin
                    req.bound = IN_W'($urandom_range(8191, 2048));
                end
                req.tx_idle_pct  = tx_pct[ph];
                req.rx_stall_pct = rx_pct[ph];
                req.drain_first  = (k == 0);
                bound_queue.push_back(req);
            end
        end
        total_requests = bound_queue.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (result_count < total_requests || count_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (64) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 5_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
